// ===== sv/dffd_pkg.sv =====
// Package for the dual-fiber deframer: beat types, codes, sizes and frame decode.
package dffd_pkg;

  localparam int FRAME_BYTES  = 12;
  localparam int HEADER_WORDS = 2;

  // Each lane word yields at most one result, so an item gives four at most.
  localparam int MAX_PER_ITEM = 4;
  localparam int CNT_W        = $clog2(MAX_PER_ITEM + 1);
  localparam int SLOT_W       = $clog2(MAX_PER_ITEM);
  localparam int BC_W         = $clog2(FRAME_BYTES + 2);
  localparam int FS_IDX_W     = $clog2(FRAME_BYTES);
  localparam int HC_W         = $clog2(HEADER_WORDS + 1);

  localparam logic [1:0] KIND_TIME  = 2'd0;
  localparam logic [1:0] KIND_FRAME = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [1:0] REG_EVENT_MARK  = 2'd0;
  localparam logic [1:0] REG_COMMA       = 2'd1;
  localparam logic [1:0] REG_SYNC_FIRST  = 2'd2;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd3;

  localparam logic [15:0] EVENT_MARK_RST  = 16'hFFFF;
  localparam logic [15:0] COMMA_RST       = 16'hFBF7;
  localparam logic [7:0]  SYNC_FIRST_RST  = 8'hBC;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'hFC;

  typedef struct packed {
    logic [15:0] lane_one_first;
    logic [15:0] lane_one_second;
    logic [15:0] lane_two_first;
    logic [15:0] lane_two_second;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        fiber_id;
    logic [63:0] time_stamp;
    logic        bunch_zero;
    logic        capid_error;
    logic [1:0]  capid;
    logic [2:0]  reserved_bits;
    logic [63:0] adc_bytes;
    logic [15:0] tdc_bits;
    logic        length_error;
    logic        last;
  } result_t;

  typedef logic [FRAME_BYTES-1:0][7:0] fstore_t;

  // Byte i of a collected frame; positions past the frame size read as zero.
  function automatic logic [7:0] frame_byte(fstore_t s, int i);
    logic [7:0] b;
    b = 8'h00;
    if (i < FRAME_BYTES) begin
      b = s[i];
    end
    return b;
  endfunction

  // Decode a finished frame into a result beat.
  function automatic result_t make_frame(fstore_t s, logic [BC_W-1:0] bc, logic fib);
    result_t    r;
    logic [7:0] b1;
    r          = '0;
    r.kind     = KIND_FRAME;
    r.fiber_id = fib;
    if (bc != BC_W'(FRAME_BYTES)) begin
      r.length_error = 1'b1;
    end else begin
      b1              = frame_byte(s, 1);
      r.bunch_zero    = b1[0];
      r.capid_error   = b1[1];
      r.capid         = b1[3:2];
      r.reserved_bits = b1[6:4];
      for (int q = 0; q < 8; q++) begin
        r.adc_bytes[8*q +: 8] = frame_byte(s, q + 2);
      end
      r.tdc_bits = {frame_byte(s, 10), frame_byte(s, 11)};
    end
    return r;
  endfunction

endpackage

// ===== sv/dual_fiber_frame_deframer.sv =====
// Dual-fiber deframer: event delimiting, comma drop, header time, frame decode.
// An accepted item is registered in the input register; its results are then registered in the result bundle.
// Throughput: one item per cycle while items give at most one result each
//   and result_stall is low; an item with more results (up to 4) holds the result
//   stage until the single output port has drained the per-item result bundle.
// Reset: rst is synchronous, active high; it clears control state and loads
//   the register defaults. Frame and header storage are not cleared.
module dual_fiber_frame_deframer
  import dffd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result
);

  // Configuration registers.
  logic [15:0] event_mark;
  logic [15:0] comma;
  logic [7:0]  sync_first;
  logic [7:0]  sync_second;

  // Input register.
  logic  inr_valid;
  item_t inr;

  // Per-event state.
  logic            in_event,  in_event_next;
  logic [HC_W-1:0] hc       [2];
  logic [HC_W-1:0] hc_next  [2];
  logic            aligned  [2];
  logic            aligned_next [2];
  logic [BC_W-1:0] bc       [2];
  logic [BC_W-1:0] bc_next  [2];
  logic            time_done, time_done_next;
  fstore_t         fstore   [2];
  fstore_t         fstore_next [2];
  logic [15:0]     hw       [4];
  logic [15:0]     hw_next  [4];

  // Result bundle: all results of one item, drained one beat per cycle while result_stall is low.
  result_t           bundle      [MAX_PER_ITEM];
  result_t           bundle_next [MAX_PER_ITEM];
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic [SLOT_W-1:0] rd_idx;

  logic out_fire;
  logic bundle_ready;
  logic move;

  assign result_valid = (cnt != '0);
  assign result       = bundle[rd_idx];
  assign out_fire     = result_valid && !result_stall;
  // The bundle frees up when empty or when its last beat leaves this cycle.
  assign bundle_ready = (cnt == '0) || (out_fire && result.last);
  assign move         = inr_valid && bundle_ready;
  assign item_stall   = inr_valid && !bundle_ready;

  // Process the registered item: the four lane words in order.
  always_comb begin
    logic [15:0]       w;
    logic              f;
    logic [7:0]        low;
    logic [7:0]        bt;
    logic              sync;
    logic [CNT_W-1:0]  n;
    logic [1:0]        hidx;
    result_t           r;
    logic [15:0]       hs [4];

    w    = '0;
    f    = 1'b0;
    low  = '0;
    bt   = '0;
    sync = 1'b0;
    hidx = '0;
    r    = '0;
    in_event_next  = in_event;
    time_done_next = time_done;
    for (int k = 0; k < 2; k++) begin
      hc_next[k]      = hc[k];
      aligned_next[k] = aligned[k];
      bc_next[k]      = bc[k];
      fstore_next[k]  = fstore[k];
    end
    for (int k = 0; k < 4; k++) begin
      hw_next[k] = hw[k];
      hs[k]      = 16'h0000;
    end
    for (int k = 0; k < MAX_PER_ITEM; k++) begin
      bundle_next[k] = '0;
    end
    n = '0;

    if (inr.lane_one_first == event_mark && inr.lane_one_second == event_mark &&
        inr.lane_two_first == event_mark && inr.lane_two_second == event_mark) begin
      if (in_event) begin
        bundle_next[0].kind = KIND_END;
        n = CNT_W'(1);
      end
      in_event_next  = 1'b1;
      time_done_next = 1'b0;
      for (int k = 0; k < 2; k++) begin
        hc_next[k]      = '0;
        aligned_next[k] = 1'b0;
        bc_next[k]      = '0;
      end
    end else if (in_event) begin
      for (int i = 0; i < 4; i++) begin
        case (i)
          0:       w = inr.lane_one_first;
          1:       w = inr.lane_one_second;
          2:       w = inr.lane_two_first;
          default: w = inr.lane_two_second;
        endcase
        f    = (i >= 2);
        low  = w[7:0];
        sync = (low == sync_first) || (low == sync_second);
        if (w != comma) begin
          if (hc_next[f] < HC_W'(HEADER_WORDS)) begin
            hidx          = {f, hc_next[f][0]};
            hw_next[hidx] = w;
            hc_next[f]    = hc_next[f] + HC_W'(1);
            if (!time_done_next && hc_next[0] >= HC_W'(HEADER_WORDS) &&
                hc_next[1] >= HC_W'(HEADER_WORDS)) begin
              // Header slots beyond the configured count read as zero.
              for (int k = 0; k < 4; k++) begin
                hs[k] = ((k % 2) < HEADER_WORDS) ? hw_next[k] : 16'h0000;
              end
              r                          = '0;
              r.kind                     = KIND_TIME;
              r.time_stamp               = {hs[0], hs[2], hs[1], hs[3]};
              bundle_next[n[SLOT_W-1:0]] = r;
              n                          = n + CNT_W'(1);
              time_done_next             = 1'b1;
            end
          end else if (aligned_next[f] || sync) begin
            if (!aligned_next[f]) begin
              aligned_next[f] = 1'b1;
              bc_next[f]      = '0;
            end else if (sync) begin
              bundle_next[n[SLOT_W-1:0]] = make_frame(fstore_next[f], bc_next[f], f);
              n                          = n + CNT_W'(1);
              bc_next[f]                 = '0;
            end
            // Low byte first; count saturates one past the frame size.
            for (int b = 0; b < 2; b++) begin
              bt = (b == 0) ? low : w[15:8];
              if (bc_next[f] < BC_W'(FRAME_BYTES)) begin
                fstore_next[f][bc_next[f][FS_IDX_W-1:0]] = bt;
              end
              if (bc_next[f] <= BC_W'(FRAME_BYTES)) begin
                bc_next[f] = bc_next[f] + BC_W'(1);
              end
            end
          end
        end
      end
    end

    if (n != '0) begin
      bundle_next[SLOT_W'(n - CNT_W'(1))].last = 1'b1;
    end
    cnt_next = n;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      event_mark  <= EVENT_MARK_RST;
      comma       <= COMMA_RST;
      sync_first  <= SYNC_FIRST_RST;
      sync_second <= SYNC_SECOND_RST;
      inr_valid   <= 1'b0;
      cnt         <= '0;
      rd_idx      <= '0;
      in_event    <= 1'b0;
      time_done   <= 1'b0;
      for (int k = 0; k < 2; k++) begin
        hc[k]      <= '0;
        aligned[k] <= 1'b0;
        bc[k]      <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_EVENT_MARK:  event_mark  <= cfg_data;
          REG_COMMA:       comma       <= cfg_data;
          REG_SYNC_FIRST:  sync_first  <= cfg_data[7:0];
          REG_SYNC_SECOND: sync_second <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (!item_stall) begin
        inr_valid <= item_valid;
      end
      if (move) begin
        cnt       <= cnt_next;
        rd_idx    <= '0;
        in_event  <= in_event_next;
        time_done <= time_done_next;
        for (int k = 0; k < 2; k++) begin
          hc[k]      <= hc_next[k];
          aligned[k] <= aligned_next[k];
          bc[k]      <= bc_next[k];
        end
      end else if (out_fire) begin
        if (result.last) begin
          cnt <= '0;
        end else begin
          rd_idx <= rd_idx + SLOT_W'(1);
        end
      end
    end
  end

  // Payload and storage, no reset.
  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      inr <= item;
    end
    if (move) begin
      for (int k = 0; k < MAX_PER_ITEM; k++) begin
        bundle[k] <= bundle_next[k];
      end
      for (int k = 0; k < 2; k++) begin
        fstore[k] <= fstore_next[k];
      end
      for (int k = 0; k < 4; k++) begin
        hw[k] <= hw_next[k];
      end
    end
  end

`ifndef SYNTHESIS
  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ({1'b0, rd_idx} < cnt))
    else $error("read slot past bundle count");

  a_end_alone: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == KIND_END) |-> (cnt == CNT_W'(1) && result.last))
    else $error("end-of-event beat shares its bundle");

  a_len_err_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == KIND_FRAME && result.length_error) |->
      (result.adc_bytes == '0 && result.tdc_bits == '0))
    else $error("length error frame carries data");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result pending after reset");

  a_stall_only_busy: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (inr_valid && result_valid))
    else $error("input stalled with empty result stage");
`endif

endmodule

// ===== tb/tb_dual_fiber_frame_deframer.sv =====
// Self-checking testbench for the dual-fiber deframer: directed table, then random events.
module tb_dual_fiber_frame_deframer;
  import dffd_pkg::*;

  // Cycles with no beat moving on either side before the run is declared hung.
  // The longest correct gap is the long output hold plus one sender gap.
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASE_ITEMS  = 16;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        item_valid;
  logic        item_stall;
  item_t       item;
  logic        result_valid;
  logic        result_stall;
  result_t     result;

  dual_fiber_frame_deframer i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Deframer predictor: its own copy of the registers and the per-event state.
  // ---------------------------------------------------------------------------
  logic [15:0] mark_word;
  logic [15:0] comma_val;
  logic [7:0]  sync_a;
  logic [7:0]  sync_b;

  bit          evt_open;                  // past the first event mark
  int unsigned hdr_seen [2];              // header words taken per fiber
  logic [15:0] hdr_word [4];              // fiber one h0,h1 then fiber two h0,h1
  bit          stamp_sent;                // time beat already produced this event
  bit          locked   [2];              // fiber has seen its first sync word
  int unsigned nbytes   [2];              // bytes in the open frame, saturating
  logic [7:0]  fbuf     [2][FRAME_BYTES];

  result_t item_beats[$];                 // beats caused by the item being predicted
  result_t due_results[$];                // beats the block still owes us

  function automatic void start_event();
    stamp_sent = 1'b0;
    for (int f = 0; f < 2; f++) begin
      hdr_seen[f] = 0;
      locked[f]   = 1'b0;
      nbytes[f]   = 0;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        fbuf[f][i] = 8'h00;
      end
    end
    for (int i = 0; i < 4; i++) begin
      hdr_word[i] = 16'h0000;
    end
  endfunction

  function automatic void reset_model();
    mark_word = EVENT_MARK_RST;
    comma_val = COMMA_RST;
    sync_a    = SYNC_FIRST_RST;
    sync_b    = SYNC_SECOND_RST;
    evt_open  = 1'b0;
    start_event();
  endfunction

  function automatic void store_byte(int f, logic [7:0] b);
    if (nbytes[f] < FRAME_BYTES) begin
      fbuf[f][nbytes[f]] = b;
    end
    if (nbytes[f] <= FRAME_BYTES) begin
      nbytes[f]++;
    end
  endfunction

  // Frame beat from what fiber f has collected; wrong length blanks the data.
  function automatic result_t frame_beat(int f);
    result_t r;
    r          = '0;
    r.kind     = KIND_FRAME;
    r.fiber_id = f[0];
    if (nbytes[f] != FRAME_BYTES) begin
      r.length_error = 1'b1;
    end else begin
      r.bunch_zero    = fbuf[f][1][0];
      r.capid_error   = fbuf[f][1][1];
      r.capid         = fbuf[f][1][3:2];
      r.reserved_bits = fbuf[f][1][6:4];
      for (int q = 0; q < 8; q++) begin
        r.adc_bytes[8*q +: 8] = fbuf[f][q + 2];
      end
      r.tdc_bits = {fbuf[f][10], fbuf[f][11]};
    end
    return r;
  endfunction

  function automatic void lane_word(int f, logic [15:0] w);
    result_t r;
    logic    is_sync;
    if (w == comma_val) return;
    if (hdr_seen[f] < HEADER_WORDS) begin
      hdr_word[f*2 + hdr_seen[f]] = w;
      hdr_seen[f]++;
      if (!stamp_sent && hdr_seen[0] >= HEADER_WORDS && hdr_seen[1] >= HEADER_WORDS) begin
        stamp_sent   = 1'b1;
        r            = '0;
        r.kind       = KIND_TIME;
        r.time_stamp = {hdr_word[0], hdr_word[2], hdr_word[1], hdr_word[3]};
        item_beats.insert(item_beats.size(), r);
      end
      return;
    end
    is_sync = (w[7:0] == sync_a) || (w[7:0] == sync_b);
    if (!locked[f]) begin
      // words ahead of the first sync word are thrown away
      if (!is_sync) return;
      locked[f] = 1'b1;
      nbytes[f] = 0;
    end else if (is_sync) begin
      item_beats.insert(item_beats.size(), frame_beat(f));
      nbytes[f] = 0;
    end
    store_byte(f, w[7:0]);
    store_byte(f, w[15:8]);
  endfunction

  function automatic void deframe_item(item_t it);
    logic [15:0] w [4];
    result_t     r;
    w[0] = it.lane_one_first;
    w[1] = it.lane_one_second;
    w[2] = it.lane_two_first;
    w[3] = it.lane_two_second;
    item_beats.delete();
    if (w[0] == mark_word && w[1] == mark_word && w[2] == mark_word && w[3] == mark_word) begin
      // a full mark closes the open event (if any) and opens a fresh one
      if (evt_open) begin
        r      = '0;
        r.kind = KIND_END;
        item_beats.insert(item_beats.size(), r);
      end
      evt_open = 1'b1;
      start_event();
    end else if (evt_open) begin
      for (int i = 0; i < 4; i++) begin
        lane_word(i / 2, w[i]);
      end
    end
    if (item_beats.size() > 0) begin
      item_beats[item_beats.size() - 1].last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every accepted beat against the oldest expectation.
  // ---------------------------------------------------------------------------
  int      mismatches = 0;
  result_t want_beat;

  task automatic cmp_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (due_results.size() == 0) begin
        $error("result beat with nothing expected: kind %0d", result.kind);
        mismatches++;
      end else begin
        want_beat = due_results.pop_front();
        cmp_field("kind",          64'(want_beat.kind),          64'(result.kind));
        cmp_field("fiber_id",      64'(want_beat.fiber_id),      64'(result.fiber_id));
        cmp_field("time_stamp",    want_beat.time_stamp,         result.time_stamp);
        cmp_field("bunch_zero",    64'(want_beat.bunch_zero),    64'(result.bunch_zero));
        cmp_field("capid_error",   64'(want_beat.capid_error),   64'(result.capid_error));
        cmp_field("capid",         64'(want_beat.capid),         64'(result.capid));
        cmp_field("reserved_bits", 64'(want_beat.reserved_bits), 64'(result.reserved_bits));
        cmp_field("adc_bytes",     want_beat.adc_bytes,          result.adc_bytes);
        cmp_field("tdc_bits",      64'(want_beat.tdc_bits),      64'(result.tdc_bits));
        cmp_field("length_error",  64'(want_beat.length_error),  64'(result.length_error));
        cmp_field("last",          64'(want_beat.last),          64'(result.last));
      end
    end
  end

  // Hang detector: counts edges where no beat moves on either channel.
  int idle_edges;
  always @(posedge clk) begin
    if (rst) begin
      idle_edges <= 0;
    end else if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_edges <= 0;
    end else begin
      idle_edges <= idle_edges + 1;
      if (idle_edges >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: random stall bursts, one long hold on request, none when calm.
  // Each pass assigns result_stall once and then waits, so no step sees two.
  // ---------------------------------------------------------------------------
  bit running  = 1'b0;
  bit calm     = 1'b0;   // last part of the run: no idling on either side
  bit steady   = 1'b0;   // sender offers back to back for the current event
  bit hold_req = 1'b0;

  initial begin
    int n;
    result_stall <= 1'b0;
    wait (running);
    forever begin
      if (hold_req) begin
        // long hold: the block backs up and has to stall its input
        hold_req = 1'b0;
        result_stall <= 1'b1;
        n = HOLD_CYCLES;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        result_stall <= 1'b1;
        n = $urandom_range(1, 15);
      end else begin
        result_stall <= 1'b0;
        n = calm ? 1 : $urandom_range(1, 20);
      end
      repeat (n) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Input side.
  // ---------------------------------------------------------------------------
  typedef struct {
    item_t   it;
    int      n_typed;   // -1: predictor decides; otherwise count of typed beats
    result_t typed;
  } dir_row_t;

  dir_row_t    script[$];
  logic [15:0] stream0[$];
  logic [15:0] stream1[$];
  int          sent;

  function automatic dir_row_t row(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                   logic [15:0] d, int n, result_t r);
    dir_row_t x;
    x.it      = item_t'({a, b, c, d});
    x.n_typed = n;
    x.typed   = r;
    return x;
  endfunction

  function automatic void add_row(dir_row_t x);
    script.insert(script.size(), x);
  endfunction

  function automatic result_t end_beat();
    result_t r;
    r      = '0;
    r.kind = KIND_END;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic result_t stamp_beat(logic [63:0] t);
    result_t r;
    r            = '0;
    r.kind       = KIND_TIME;
    r.time_stamp = t;
    r.last       = 1'b1;
    return r;
  endfunction

  // Offer one beat, hold it until taken, then book what it should produce.
  task automatic send_item(item_t it, int n_typed, result_t typed);
    if (!calm && !steady && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    deframe_item(it);
    if (n_typed < 0) begin
      foreach (item_beats[i]) due_results.insert(due_results.size(), item_beats[i]);
    end else if (n_typed > 0) begin
      due_results.insert(due_results.size(), typed);
    end
    sent++;
  endtask

  // Wait until the block owes nothing and whatever is still inside has drained.
  task automatic settle();
    item_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_EVENT_MARK:  mark_word = val;
      REG_COMMA:       comma_val = val;
      REG_SYNC_FIRST:  sync_a    = val[7:0];
      REG_SYNC_SECOND: sync_b    = val[7:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [15:0] mark, logic [15:0] comma, logic [7:0] sa,
                           logic [7:0] sb);
    write_reg(REG_EVENT_MARK, mark);
    write_reg(REG_COMMA, comma);
    write_reg(REG_SYNC_FIRST, {8'h00, sa});
    write_reg(REG_SYNC_SECOND, {8'h00, sb});
    cfg_we <= 1'b0;
  endtask

  // Data word whose low byte cannot be taken for a sync byte.
  function automatic logic [15:0] plain_word();
    logic [15:0] w;
    do begin
      w = 16'($urandom);
    end while (w[7:0] == sync_a || w[7:0] == sync_b);
    return w;
  endfunction

  // One fiber's stream for an event: headers, pre-sync junk, frames, commas.
  function automatic void build_stream(ref logic [15:0] q[$]);
    int n_frames;
    int n_data;
    q.delete();
    for (int h = 0; h < HEADER_WORDS; h++) q.insert(q.size(), 16'($urandom));
    repeat ($urandom_range(0, 2)) q.insert(q.size(), plain_word());
    n_frames = $urandom_range(1, 3);
    for (int k = 0; k < n_frames; k++) begin
      q.insert(q.size(), {8'($urandom), ($urandom_range(0, 1) != 0) ? sync_a : sync_b});
      // mostly a well-sized frame, now and then too short or too long
      n_data = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 8) : FRAME_BYTES / 2 - 1;
      repeat (n_data) q.insert(q.size(), plain_word());
    end
    if ($urandom_range(0, 4) != 0) begin
      q.insert(q.size(), {8'($urandom), sync_a});   // closing sync flushes the last frame
    end
    if ($urandom_range(0, 7) == 0) begin
      q = q[0:$urandom_range(0, q.size() - 1)];   // event cut off mid-stream
    end
    for (int i = q.size() - 1; i >= 0; i--) begin
      if ($urandom_range(0, 7) == 0) q.insert(i, comma_val);
    end
  endfunction

  function automatic logic [15:0] next_word(ref logic [15:0] q[$]);
    return (q.size() != 0) ? q.pop_front() : comma_val;
  endfunction

  task automatic send_random_event();
    item_t it;
    steady = ($urandom_range(0, 2) == 0);
    send_item(item_t'({4{mark_word}}), -1, '0);
    build_stream(stream0);
    build_stream(stream1);
    while (stream0.size() != 0 || stream1.size() != 0) begin
      it.lane_one_first  = next_word(stream0);
      it.lane_one_second = next_word(stream0);
      it.lane_two_first  = next_word(stream1);
      it.lane_two_second = next_word(stream1);
      case ($urandom_range(0, 19))
        0: it = item_t'({$urandom, $urandom});           // pure noise beat
        1: begin                                          // mark on some lanes only
          it.lane_one_first  = mark_word;
          it.lane_one_second = mark_word;
        end
        default: ;
      endcase
      send_item(it, -1, '0);
    end
  endtask

  initial begin
    logic [15:0] rmark;
    logic [15:0] rcomma;
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_EVENT_MARK;
    cfg_data   <= 16'h0000;
    item_valid <= 1'b0;
    item       <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    reset_model();
    running = 1'b1;

    // Directed table at reset register values (mark FFFF, comma FBF7, sync BC/FC).
    add_row(row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, '0)); // preamble
    add_row(row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 0, '0)); // partial mark
    add_row(row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, '0)); // opens event
    add_row(row(16'hFFFF, 16'hFBF7, 16'h0000, 16'hFBF7, -1, '0));
    // completes both headers at lane two first; trailing word is pre-sync junk
    add_row(row(16'h1234, 16'hFBF7, 16'hABCD, 16'h5678, 1,
                stamp_beat(64'hFFFF_0000_1234_ABCD)));
    add_row(row(16'h7FBC, 16'h0201, 16'hFFFC, 16'h8180, -1, '0));
    add_row(row(16'h0403, 16'h0605, 16'h7E7D, 16'h7C7B, -1, '0));
    add_row(row(16'h0807, 16'h0A09, 16'hFBF7, 16'h0000, -1, '0));
    add_row(row(16'h55BC, 16'h3322, 16'hFFFF, 16'h01FC, -1, '0));
    // four short frames from one beat: the most any item can give
    add_row(row(16'h00BC, 16'h00BC, 16'h00FC, 16'h00FC, -1, '0));
    repeat (4) add_row(row(16'h2222, 16'h2222, 16'h3333, 16'h3333, -1, '0));
    add_row(row(16'h44BC, 16'h4444, 16'h44FC, 16'h4444, -1, '0)); // overlong
    add_row(row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, end_beat()));
    add_row(row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, end_beat())); // empty
    add_row(row(16'hFBF7, 16'hFBF7, 16'hFBF7, 16'hFBF7, 0, '0)); // all comma
    add_row(row(16'h0001, 16'h0002, 16'h0003, 16'h0004, 1,
                stamp_beat(64'h0001_0003_0002_0004)));
    add_row(row(16'h00BC, 16'hFFFF, 16'h00FC, 16'h0000, -1, '0));
    add_row(row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, end_beat())); // drops partial
    foreach (script[i]) send_item(script[i].it, script[i].n_typed, script[i].typed);
    settle();

    // Random events under several register settings, extremes included.
    for (int p = 0; p < 4; p++) begin
      case (p)
        1: begin
          configure(16'h0000, 16'hFFFF, 8'h00, 8'hFF);
          hold_req = 1'b1;
        end
        2: configure(16'hFFFF, 16'h0000, 8'hFF, 8'h00);
        3: begin
          rmark = 16'($urandom);
          do rcomma = 16'($urandom); while (rcomma == rmark);
          configure(rmark, rcomma, 8'($urandom), 8'($urandom));
          calm = 1'b1;
        end
        default: ;
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) send_random_event();
      if (p == 0) begin
        // sender waits out every owed beat before going on
        item_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
      end else begin
        settle();
      end
    end
    steady = 1'b1;
    send_item(item_t'({4{mark_word}}), -1, '0);   // closes the last event
    settle();

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
